// ----- rtl/dual_port_adc_sweep_sequencer_assert.svh -----
// Assertion macros shared by the sweep sequencer modules.
`ifndef DUAL_PORT_ADC_SWEEP_SEQUENCER_ASSERT_SVH
`define DUAL_PORT_ADC_SWEEP_SEQUENCER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define DPAS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dpas assertion failed");

// Consequent checked in the cycle after the antecedent.
`define DPAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpas next-cycle assertion failed");

`endif

// ----- rtl/dpas_pkg.sv -----
package dpas_pkg;

  localparam int unsigned CHANNELS   = 32;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned CHAN_W     = 5;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned CMD_W      = 10;
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Last transfer number of a sweep: CHANNELS conversions plus the dropped one.
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CHANNELS + 1);
  localparam logic [SLOT_W-1:0] SLOT_CHAN = SLOT_W'(CHANNELS);

  typedef enum logic {
    OP_START = 1'b0,
    OP_RX    = 1'b1
  } op_e;

  // One classified item, front to back.
  typedef struct packed {
    logic              cmd_valid;
    logic [CHAN_W-1:0] cmd_chan;
    logic              samp_valid;
    logic [CHAN_W-1:0] chan;
    logic              done;
    logic              dbl;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
  } entry_t;

  function automatic logic [CMD_W-1:0] cmd_double(input logic [CHAN_W-1:0] ch);
    logic [CMD_W-1:0] r;
    for (int i = 0; i < CHAN_W; i++) begin
      r[2*i]   = ch[i];
      r[2*i+1] = ch[i];
    end
    return r;
  endfunction

  // Every other bit of w, starting at bit 1 (odd) or bit 0 (even).
  function automatic logic [7:0] pick_bits(input logic [WORD_W-1:0] w, input logic odd);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = odd ? w[2*i+1] : w[2*i];
    end
    return r;
  endfunction

endpackage

// ----- rtl/dpas_front.sv -----
module dpas_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          op_i,
  input  logic [dpas_pkg::WORD_W-1:0]   rx_word_first_i,
  input  logic [dpas_pkg::WORD_W-1:0]   rx_word_second_i,
  input  logic                          dbl_mode_i,
  output logic                          push_o,
  output dpas_pkg::entry_t              entry_o
);
  import dpas_pkg::*;

  logic              active_q, active_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] nxt;
  logic [SLOT_W-1:0] ch_full;
  logic              accept;

  assign accept  = in_valid_i && in_ready_i;
  assign push_o  = accept;
  assign nxt     = slot_q + SLOT_W'(1);
  assign ch_full = slot_q - SLOT_W'(2);

  always_comb begin
    active_d         = active_q;
    slot_d           = slot_q;
    entry_o          = '0;
    entry_o.dbl      = dbl_mode_i;
    entry_o.w0       = rx_word_first_i;
    entry_o.w1       = rx_word_second_i;
    if (op_i == OP_START) begin
      active_d         = 1'b1;
      slot_d           = SLOT_W'(1);
      entry_o.cmd_valid = 1'b1;
      entry_o.cmd_chan  = CHAN_W'(1);
    end else if (active_q) begin
      if (slot_q < SLOT_W'(1) || slot_q > SLOT_LAST) begin
        active_d = 1'b0;
        slot_d   = '0;
      end else begin
        if (slot_q >= SLOT_W'(2)) begin
          entry_o.samp_valid = 1'b1;
          entry_o.chan       = ch_full[CHAN_W-1:0];
        end
        if (slot_q < SLOT_LAST) begin
          entry_o.cmd_valid = 1'b1;
          entry_o.cmd_chan  = (nxt < SLOT_CHAN) ? nxt[CHAN_W-1:0] : '0;
          slot_d            = nxt;
        end else begin
          entry_o.done = 1'b1;
          active_d     = 1'b0;
          slot_d       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      slot_q   <= '0;
    end else if (accept) begin
      active_q <= active_d;
      slot_q   <= slot_d;
    end
  end

`include "dual_port_adc_sweep_sequencer_assert.svh"

  `DPAS_ASSERT(a_idle_slot_zero, clk_i, rst_ni, active_q || slot_q == '0)
  `DPAS_ASSERT(a_slot_in_range, clk_i, rst_ni, !active_q || (slot_q >= SLOT_W'(1) && slot_q <= SLOT_LAST))
  `DPAS_ASSERT_NEXT(a_start_slot, clk_i, rst_ni, accept && op_i == OP_START, active_q && slot_q == SLOT_W'(1))

endmodule

// ----- rtl/dpas_fifo.sv -----
module dpas_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dpas_pkg::entry_t entry_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output dpas_pkg::entry_t entry_o
);
  import dpas_pkg::*;

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + FIFO_CNT_W'(do_push) - FIFO_CNT_W'(do_pop);
    end
  end

`include "dual_port_adc_sweep_sequencer_assert.svh"

  `DPAS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FIFO_CNT_W'(FIFO_DEPTH))

endmodule

// ----- rtl/dpas_back.sv -----
module dpas_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  dpas_pkg::entry_t             entry_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         command_valid_o,
  output logic [dpas_pkg::CMD_W-1:0]   command_word_o,
  output logic                         samples_valid_o,
  output logic [dpas_pkg::CHAN_W-1:0]  channel_index_o,
  output logic [dpas_pkg::WORD_W-1:0]  sample_port_a_o,
  output logic [dpas_pkg::WORD_W-1:0]  sample_port_b_o,
  output logic                         sweep_done_o
);
  import dpas_pkg::*;

  logic              out_valid_q;
  logic              load;
  logic [WORD_W-1:0] sa_raw, sb_raw;
  logic [CMD_W-1:0]  cw_d;
  logic [WORD_W-1:0] sa_d, sb_d;

  assign load  = valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load;

  // de-interleave: odd bits to port A, even bits to port B
  always_comb begin
    if (entry_i.dbl) begin
      sa_raw = {pick_bits(entry_i.w0, 1'b1), pick_bits(entry_i.w1, 1'b1)};
      sb_raw = {pick_bits(entry_i.w0, 1'b0), pick_bits(entry_i.w1, 1'b0)};
    end else begin
      sa_raw = entry_i.w0;
      sb_raw = entry_i.w1;
    end
    sa_d = '0;
    sb_d = '0;
    if (entry_i.samp_valid) begin
      sa_d = {sa_raw[WORD_W-1:1], (entry_i.chan != '0)};  // channel 0 marks the frame
      sb_d = {sb_raw[WORD_W-1:1], 1'b1};
    end
    cw_d = '0;
    if (entry_i.cmd_valid) begin
      cw_d = entry_i.dbl ? cmd_double(entry_i.cmd_chan)
                         : {{(CMD_W-CHAN_W){1'b0}}, entry_i.cmd_chan};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      command_valid_o <= entry_i.cmd_valid;
      command_word_o  <= cw_d;
      samples_valid_o <= entry_i.samp_valid;
      channel_index_o <= entry_i.chan;
      sample_port_a_o <= sa_d;
      sample_port_b_o <= sb_d;
      sweep_done_o    <= entry_i.done;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/dual_port_adc_sweep_sequencer.sv -----
// Path: each accepted transfer goes into the queue, then into the output register,
// where out_valid_o offers the result until out_ready_i takes it.
// Throughput: one item per cycle while the result side is ready; the front,
// the two-entry queue and the output register each move one item a cycle.
// A held result fills the queue and drops in_ready_o until it has room again.
// Reset (rst_ni low, asynchronous): sweep idle, transfer slot 0, queue empty,
// no result pending, double-bit mode off.
module dual_port_adc_sweep_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: double-bit mode
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         op_i,
  input  logic [dpas_pkg::WORD_W-1:0]  rx_word_first_i,
  input  logic [dpas_pkg::WORD_W-1:0]  rx_word_second_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         command_valid_o,
  output logic [dpas_pkg::CMD_W-1:0]   command_word_o,
  output logic                         samples_valid_o,
  output logic [dpas_pkg::CHAN_W-1:0]  channel_index_o,
  output logic [dpas_pkg::WORD_W-1:0]  sample_port_a_o,
  output logic [dpas_pkg::WORD_W-1:0]  sample_port_b_o,
  output logic                         sweep_done_o
);
  import dpas_pkg::*;

  logic   dbl_mode_q;
  logic   push;
  logic   fifo_full;
  logic   fifo_valid;
  logic   pop;
  entry_t fe_entry;
  entry_t be_entry;

  // Mode register, sampled by the front per item; user must write it only while idle (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbl_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      dbl_mode_q <= cfg_wdata_i;
    end
  end

  // Front takes a transfer whenever the queue has room, independent of the
  // result side.
  assign in_ready_o = !fifo_full;

  // Front: slot counter and sweep state; tags each item with what to emit.
  dpas_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .op_i             (op_i),
    .rx_word_first_i  (rx_word_first_i),
    .rx_word_second_i (rx_word_second_i),
    .dbl_mode_i       (dbl_mode_q),
    .push_o           (push),
    .entry_o          (fe_entry)
  );

  // Short queue decoupling front and back stalls.
  dpas_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (fe_entry),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .entry_o (be_entry)
  );

  // Back: command encoding, reply de-interleave, LSB marking, output register.
  dpas_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (fifo_valid),
    .entry_i         (be_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .command_valid_o (command_valid_o),
    .command_word_o  (command_word_o),
    .samples_valid_o (samples_valid_o),
    .channel_index_o (channel_index_o),
    .sample_port_a_o (sample_port_a_o),
    .sample_port_b_o (sample_port_b_o),
    .sweep_done_o    (sweep_done_o)
  );

endmodule

// ----- sim/dual_port_adc_sweep_sequencer_tb.sv -----
`timescale 1ns / 1ps

module dual_port_adc_sweep_sequencer_tb;
  import dpas_pkg::*;

  // Cycles with no transfer on either channel before the run is declared hung.
  // The longest legal quiet stretch is the long receiver hold plus a few
  // idle gaps, so this leaves a wide margin.
  localparam int unsigned STALL_LIMIT = 2000;
  // Receive transfers per sweep: one per transfer slot; the start comes on top.
  localparam int unsigned RX_PER_SWEEP = CHANNELS + 1;
  localparam int unsigned RANDOM_ITEMS = 1300;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic                cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                op_i;
  logic [WORD_W-1:0]   rx_word_first_i;
  logic [WORD_W-1:0]   rx_word_second_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                command_valid_o;
  logic [CMD_W-1:0]    command_word_o;
  logic                samples_valid_o;
  logic [CHAN_W-1:0]   channel_index_o;
  logic [WORD_W-1:0]   sample_port_a_o;
  logic [WORD_W-1:0]   sample_port_b_o;
  logic                sweep_done_o;

  // One result of the block, as the predictor works it out.
  typedef struct packed {
    logic              cmd_valid;
    logic [CMD_W-1:0]  cmd_word;
    logic              samp_valid;
    logic [CHAN_W-1:0] chan;
    logic [WORD_W-1:0] port_a;
    logic [WORD_W-1:0] port_b;
    logic              done;
  } sweep_result_t;

  // Predictor state, mirrors the block's sweep counter and mode register.
  logic              pred_dbl;
  logic [SLOT_W-1:0] pred_slot;
  logic              pred_active;

  sweep_result_t pending_results[$];
  int unsigned   error_count;
  int unsigned   sweep_items;
  int unsigned   stall_cycles;

  // Random idling: each side toggles a no-gap stretch now and then, so both
  // back-to-back traffic and gaps at every point of a sweep get exercised.
  bit          tx_quiet;
  bit          rx_quiet;
  int unsigned rx_hold_len;

  dual_port_adc_sweep_sequencer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .rx_word_first_i  (rx_word_first_i),
    .rx_word_second_i (rx_word_second_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .command_valid_o  (command_valid_o),
    .command_word_o   (command_word_o),
    .samples_valid_o  (samples_valid_o),
    .channel_index_o  (channel_index_o),
    .sample_port_a_o  (sample_port_a_o),
    .sample_port_b_o  (sample_port_b_o),
    .sweep_done_o     (sweep_done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Convert command for a channel; in double-bit mode every bit is sent twice.
  function automatic logic [CMD_W-1:0] channel_command(input logic [CHAN_W-1:0] ch);
    logic [CMD_W-1:0] cmd;
    cmd = '0;
    if (!pred_dbl) begin
      cmd = CMD_W'(ch);
    end else begin
      for (int i = 0; i < CHAN_W; i++) begin
        cmd[2*i]   = ch[i];
        cmd[2*i+1] = ch[i];
      end
    end
    return cmd;
  endfunction

  // Advances the sweep by one accepted item and returns the result it causes.
  function automatic sweep_result_t predict_sweep(input logic op, input logic [WORD_W-1:0] w_hi,
                                                  input logic [WORD_W-1:0] w_lo);
    sweep_result_t     r;
    logic [SLOT_W-1:0] k;
    logic [SLOT_W-1:0] nxt;
    logic [CHAN_W-1:0] ch;
    r = '0;
    if (op == OP_START) begin
      // a start always wins, even in the middle of a sweep
      pred_active = 1'b1;
      pred_slot   = SLOT_W'(1);
      r.cmd_valid = 1'b1;
      r.cmd_word  = channel_command(CHAN_W'(1));
    end else if (pred_active) begin
      k = pred_slot;
      if (k < SLOT_W'(1) || k > SLOT_LAST) begin
        pred_active = 1'b0;
        pred_slot   = '0;
      end else begin
        // slot 1 reply is the pipeline fill, dropped; slot k carries channel k-2
        if (k >= SLOT_W'(2)) begin
          ch           = CHAN_W'(k - SLOT_W'(2));
          r.samp_valid = 1'b1;
          r.chan       = ch;
          if (pred_dbl) begin
            // odd bits feed port A, even bits port B; first word is the high byte
            for (int i = 0; i < 8; i++) begin
              r.port_a[8+i] = w_hi[2*i+1];
              r.port_a[i]   = w_lo[2*i+1];
              r.port_b[8+i] = w_hi[2*i];
              r.port_b[i]   = w_lo[2*i];
            end
          end else begin
            r.port_a = w_hi;
            r.port_b = w_lo;
          end
          // channel 0 on port A carries the frame marker (LSB low)
          r.port_a[0] = (ch != '0);
          r.port_b[0] = 1'b1;
        end
        if (k < SLOT_LAST) begin
          nxt         = k + SLOT_W'(1);
          r.cmd_valid = 1'b1;
          r.cmd_word  = channel_command((nxt < SLOT_CHAN) ? CHAN_W'(nxt) : '0);
          pred_slot   = nxt;
        end else begin
          r.done      = 1'b1;
          pred_active = 1'b0;
          pred_slot   = '0;
        end
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: sampled at the falling edge, where every signal has settled and
  // holds the value the next rising edge will see.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (rst_ni === 1'b1 && in_valid_i && in_ready_o) begin
      pending_results.push_back(predict_sweep(op_i, rx_word_first_i, rx_word_second_i));
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(negedge clk_i) begin
    sweep_result_t want;
    if (rst_ni === 1'b1 && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (command_valid_o !== want.cmd_valid)
          report_mismatch("command_valid", command_valid_o, want.cmd_valid);
        if (command_word_o !== want.cmd_word)
          report_mismatch("command_word", command_word_o, want.cmd_word);
        if (samples_valid_o !== want.samp_valid)
          report_mismatch("samples_valid", samples_valid_o, want.samp_valid);
        if (channel_index_o !== want.chan)
          report_mismatch("channel_index", channel_index_o, want.chan);
        if (sample_port_a_o !== want.port_a)
          report_mismatch("sample_port_a", sample_port_a_o, want.port_a);
        if (sample_port_b_o !== want.port_b)
          report_mismatch("sample_port_b", sample_port_b_o, want.port_b);
        if (sweep_done_o !== want.done)
          report_mismatch("sweep_done", sweep_done_o, want.done);
      end
    end
  end

  // Hang detector: counts cycles in which neither channel moves a transfer.
  always @(negedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls per result, plus an optional long hold
  // requested by a test and counted here.
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned wait_n;
    bit          taken;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len > 0) begin
        wait_n      = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        wait_n = rx_quiet ? 0 : $urandom_range(0, 14);
      end
      if (wait_n > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk_i);
        taken = out_valid_o;
        @(posedge clk_i);
      end
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side. All tasks are entered and left just after a rising edge.
  // ---------------------------------------------------------------------------

  task automatic send_item(input op_e op, input logic [WORD_W-1:0] w_hi,
                           input logic [WORD_W-1:0] w_lo);
    int unsigned gap;
    bit          taken;
    gap = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    rx_word_first_i  <= w_hi;
    rx_word_second_i <= w_lo;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
  endtask

  // Drop valid, then wait until every outstanding result has been taken and
  // the queue and the output register have surely gone quiet.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_double_mode(input logic dbl);
    drain_block();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dbl;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pred_dbl = dbl;
  endtask

  // Mostly uniform, with a fair share of the corner patterns.
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return 16'hAAAA;
      3:       return 16'h5555;
      default: return WORD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Start plus n receive transfers with random content.
  task automatic run_sweep(input int unsigned n_rx);
    send_item(OP_START, rand_word(), rand_word());
    sweep_items++;
    repeat (n_rx) begin
      send_item(OP_RX, rand_word(), rand_word());
      sweep_items++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Receive transfers before any start are ignored: all-zero results.
  task automatic test_rx_while_idle();
    send_item(OP_RX, 16'h0000, 16'hFFFF);
    send_item(OP_RX, 16'hFFFF, 16'h0000);
    send_item(OP_RX, 16'hAAAA, 16'h5555);
  endtask

  // Single-bit mode: dropped first reply, channel 0 frame marker, LSB forcing,
  // then a start in mid-sweep that abandons the sweep.
  task automatic test_single_mode_restart();
    set_double_mode(1'b0);
    send_item(OP_START, 16'h1234, 16'h5678);
    send_item(OP_RX,    16'hFFFF, 16'hFFFF);
    send_item(OP_RX,    16'hFFFF, 16'hFFFF);
    send_item(OP_RX,    16'h0000, 16'h0000);
    send_item(OP_RX,    16'h8000, 16'h7FFE);
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_RX,    16'h5555, 16'hAAAA);
    send_item(OP_RX,    16'h0000, 16'h0000);
  endtask

  // Double-bit mode: doubled commands and de-interleaved replies.
  task automatic test_double_mode();
    set_double_mode(1'b1);
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_RX,    16'hFFFF, 16'hFFFF);
    send_item(OP_RX,    16'hAAAA, 16'h5555);
    send_item(OP_RX,    16'hFFFF, 16'h0000);
    send_item(OP_RX,    16'h1234, 16'h8001);
    send_item(OP_RX,    16'h5555, 16'hAAAA);
    set_double_mode(1'b0);
  endtask

  // Receiver holds off for a long stretch while items keep coming back to
  // back: the queue fills and in_ready must drop without losing anything.
  task automatic test_backpressure();
    bit saved_quiet;
    saved_quiet = tx_quiet;
    tx_quiet    = 1'b1;
    rx_hold_len = 150;
    run_sweep(RX_PER_SWEEP);
    tx_quiet = saved_quiet;
  endtask

  // Sender pauses mid-sweep until every result is in, then carries on.
  task automatic test_drain_pause();
    run_sweep(10);
    drain_block();
    repeat (RX_PER_SWEEP - 10) begin
      send_item(OP_RX, rand_word(), rand_word());
      sweep_items++;
    end
  endtask

  // Mostly complete sweeps with random payload and mode; some abandoned
  // sweeps and stray receive transfers as noise.
  task automatic test_random_sweeps();
    int unsigned pick;
    while (sweep_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        run_sweep(RX_PER_SWEEP);
      end else if (pick == 6) begin
        run_sweep($urandom_range(1, RX_PER_SWEEP - 1));
      end else if (pick == 7) begin
        // may land on an idle block or extend an abandoned sweep
        repeat ($urandom_range(1, 4)) send_item(OP_RX, rand_word(), rand_word());
      end else begin
        set_double_mode(logic'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic finish_run();
    drain_block();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  endtask

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = 1'b0;
    in_valid_i       = 1'b0;
    op_i             = OP_START;
    rx_word_first_i  = '0;
    rx_word_second_i = '0;
    pred_dbl         = 1'b0;
    pred_slot        = '0;
    pred_active      = 1'b0;
    error_count      = 0;
    sweep_items      = 0;
    stall_cycles     = 0;
    tx_quiet         = 1'b0;
    rx_quiet         = 1'b0;
    rx_hold_len      = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_rx_while_idle();
    test_single_mode_restart();
    test_double_mode();
    test_backpressure();
    test_drain_pause();
    test_random_sweeps();
    finish_run();
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dpas_pkg.sv
rtl/dpas_front.sv
rtl/dpas_fifo.sv
rtl/dpas_back.sv
rtl/dual_port_adc_sweep_sequencer.sv
sim/dual_port_adc_sweep_sequencer_tb.sv
